// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorted list engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list engine: next-cycle check failed");

`endif

// ===== rtl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg
// Types and constants shared by the sorted list engine and its cells.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int DATA_W       = 32;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 2;
    localparam int HELD_W       = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE      = 2'd0,
        STS_FOUND     = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic              compare;
        logic              insert;
        logic              remove;
        logic [DATA_W-1:0] key;
    } slc_ctrl_t;

endpackage

// ===== rtl/slc_cell.sv =====
// ----------------------------------------------------------------------------
// slc_cell
// One slot of the sorted chain: holds a value and its compare flags.
// ----------------------------------------------------------------------------
module slc_cell
    import slc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  slc_ctrl_t         ctrl,
    input  logic              occupied,
    input  logic [DATA_W-1:0] left_val,
    input  logic              left_lt,
    input  logic [DATA_W-1:0] right_val,
    output logic [DATA_W-1:0] val,
    output logic              lt,
    output logic              eq
);

    logic [DATA_W-1:0] val_reg;
    logic              lt_reg;
    logic              eq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.compare)
        begin
            lt_reg <= occupied && ($signed(val_reg) < $signed(ctrl.key));
            eq_reg <= occupied && (val_reg == ctrl.key);
        end
    end

    // On insert the first cell not below the key takes the new value and every
    // cell after it moves one place right; on delete they all move one place left.
    always_ff @(posedge clk)
    begin
        if (ctrl.insert && !lt_reg)
        begin
            val_reg <= left_lt ? ctrl.key : left_val;
        end
        else if (ctrl.remove && !lt_reg)
        begin
            val_reg <= right_val;
        end
    end

    assign val = val_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

// ===== rtl/sorted_list_engine.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine
// Sorted table of signed values with insert, search and delete requests.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata fields (lowest bit first)
//  --------+-----------+---------------------------------------------------
//  s_*     | in        | action[1:0], value[33:2], zero pad[39:34]
//  m_*     | out       | status[1:0], entries_held[6:2], zero pad[7]
//
// Each request has two steps: in the accept cycle every cell compares its
// value with the key, and in the apply step the chain shifts and the result
// is loaded into the output register. The cell chain has a single set of
// compare flags, so one request is in flight at a time.
// Reset clears the entry count and the handshake state; cell values are left
// as they are and only slots below the count are ever used.
// While a result waits on m_tready the next request is still accepted; it
// then holds in the apply step until the output register is free.
//
module sorted_list_engine
    import slc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action[1:0], value[33:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // status[1:0], entries_held[6:2]
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_APPLY = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    action_t           action_reg;
    logic [DATA_W-1:0] value_reg;
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;

    logic              accept;
    logic              apply_fire;
    logic              found;
    logic              is_full;
    status_t           status;
    slc_ctrl_t         ctrl;

    logic [DATA_W-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;

    logic [CNT_W+HELD_W-1:0] held_ext;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign apply_fire = (state_reg == ST_APPLY) && (!out_valid_reg || m_tready);

    // The cells compare against the incoming value during the accept cycle
    // and use the captured copy when the chain is rewritten.
    assign found   = |cell_eq;
    assign is_full = (count_reg >= CNT_W'(CAPACITY));

    always_comb
    begin
        ctrl.compare = accept;
        ctrl.key     = accept ? s_tdata[DATA_W+ACTION_W-1:ACTION_W] : value_reg;
        ctrl.insert  = apply_fire && (action_reg == ACT_INSERT) && !is_full;
        ctrl.remove  = apply_fire && (action_reg == ACT_DELETE) && found;
    end

    always_comb
    begin
        status     = STS_DONE;
        count_next = count_reg;
        unique case (action_reg)
            ACT_INSERT:
            begin
                if (is_full)
                begin
                    status = STS_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_SEARCH:
            begin
                status = found ? STS_FOUND : STS_NOT_FOUND;
            end
            ACT_DELETE:
            begin
                if (found)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status = STS_NOT_FOUND;
                end
            end
            default:
            begin
                status = STS_DONE;
            end
        endcase
    end

    // The reported count wraps at 32, as the five-bit field allows.
    assign held_ext = {{HELD_W{1'b0}}, count_next};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action_t'(s_tdata[ACTION_W-1:0]);
            value_reg  <= s_tdata[DATA_W+ACTION_W-1:ACTION_W];
        end
        if (apply_fire)
        begin
            out_data_reg <= {1'b0, held_ext[HELD_W-1:0], status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Chain of cells: slot 0 holds the smallest value.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_val;
            logic              left_lt;
            logic [DATA_W-1:0] right_val;

            if (gi == 0)
            begin : g_first
                assign left_val = value_reg;
                assign left_lt  = 1'b1;
            end
            else
            begin : g_inner
                assign left_val = cell_val[gi-1];
                assign left_lt  = cell_lt[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_val = cell_val[gi];
            end
            else
            begin : g_body
                assign right_val = cell_val[gi+1];
            end

            slc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .occupied  (CNT_W'(gi) < count_reg),
                .left_val  (left_val),
                .left_lt   (left_lt),
                .right_val (right_val),
                .val       (cell_val[gi]),
                .lt        (cell_lt[gi]),
                .eq        (cell_eq[gi])
            );
        end
    endgenerate

    // The count never passes the capacity of the chain.
    `SLE_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    // An accepted request always moves on to the apply step.
    `SLE_ASSERT_NEXT(a_accept_apply, clk, rst_n, accept, state_reg == ST_APPLY)
    // The count only changes when a request is applied.
    `SLE_ASSERT_NEXT(a_count_hold, clk, rst_n, !apply_fire, $stable(count_reg))
    // A full status goes out only with the chain at capacity.
    `SLE_ASSERT_IMPL(a_full_status, clk, rst_n,
        m_tvalid && (m_tdata[STATUS_W-1:0] == STS_FULL), count_reg == CNT_W'(CAPACITY))

endmodule

// ===== tb/sv/sorted_list_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_list_checker
// Watches both stream channels of the sorted list engine, keeps its own copy
// of the sorted table, and compares every reply with the predicted one.
// ----------------------------------------------------------------------------
module sorted_list_checker
    import slc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // action[1:0], value[33:2]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // status[1:0], entries_held[6:2]
    output int          errors,
    output int          pending,
    output int          replies,
    output int          full_hits,
    output int          found_hits,
    output int          miss_hits,
    output int          peak_held
);

    typedef struct {
        status_t           status;
        logic [HELD_W-1:0] held;
    } table_reply_t;

    logic signed [DATA_W-1:0] held_vals [CAPACITY];
    int                       held_count;
    table_reply_t             pending_replies [$];

    // Applies one request to the local table and returns its status.
    task automatic table_apply(input action_t act, input logic signed [DATA_W-1:0] key,
                               output status_t st);
        int slot;
        int k;
        st   = STS_DONE;
        slot = 0;
        case (act)
            ACT_INSERT:
            begin
                if (held_count >= CAPACITY)
                    st = STS_FULL;
                else
                begin
                    // The new value goes in front of the first one not smaller.
                    while (slot < held_count && held_vals[slot] < key)
                        slot++;
                    for (k = held_count; k > slot; k--)
                        held_vals[k] = held_vals[k-1];
                    held_vals[slot] = key;
                    held_count++;
                end
            end
            ACT_SEARCH:
            begin
                st = STS_NOT_FOUND;
                for (k = 0; k < held_count; k++)
                    if (held_vals[k] == key)
                        st = STS_FOUND;
            end
            ACT_DELETE:
            begin
                while (slot < held_count && held_vals[slot] != key)
                    slot++;
                if (slot >= held_count)
                    st = STS_NOT_FOUND;
                else
                begin
                    for (k = slot; k + 1 < held_count; k++)
                        held_vals[k] = held_vals[k+1];
                    held_count--;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t      want;
        status_t           got_status;
        logic [HELD_W-1:0] got_held;
        status_t           st;
        if (!rst_n)
        begin
            held_count = 0;
            pending_replies.delete();
            errors     = 0;
            pending    = 0;
            replies    = 0;
            full_hits  = 0;
            found_hits = 0;
            miss_hits  = 0;
            peak_held  = 0;
        end
        else
        begin
            // The reply side is checked first; it always belongs to an older request.
            if (m_tvalid && m_tready)
            begin
                got_status = status_t'(m_tdata[1:0]);
                got_held   = m_tdata[6:2];
                replies++;
                if (pending_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: reply with no request outstanding: status %0d held %0d",
                             $time, got_status, got_held);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got_status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got_status);
                    end
                    if (got_held !== want.held)
                    begin
                        errors++;
                        $display("%0t: entries_held mismatch: expected %0d, actual %0d",
                                 $time, want.held, got_held);
                    end
                    if (m_tdata[7] !== 1'b0)
                    begin
                        errors++;
                        $display("%0t: pad bit mismatch: expected 0, actual %b",
                                 $time, m_tdata[7]);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                table_apply(action_t'(s_tdata[1:0]), s_tdata[33:2], st);
                want.status = st;
                want.held   = held_count[HELD_W-1:0];
                pending_replies.push_back(want);
                if (st == STS_FULL)
                    full_hits++;
                if (st == STS_FOUND)
                    found_hits++;
                if (st == STS_NOT_FOUND)
                    miss_hits++;
                if (held_count > peak_held)
                    peak_held = held_count;
            end
            pending = pending_replies.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, search, delete and no-op requests into the sorted list engine with
// random gaps and reply stalls; a checker beside the block grades each reply.
// ----------------------------------------------------------------------------
module tb_top;
    import slc_pkg::*;

    localparam int REQUEST_TARGET = 1500;
    localparam int LIMIT_CYCLES   = 600000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // action[1:0], value[33:2]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // status[1:0], entries_held[6:2]

    int errors;
    int pending;
    int replies;
    int full_hits;
    int found_hits;
    int miss_hits;
    int peak_held;
    int cycles;
    int sent;

    // When set, neither side idles, so back-to-back requests are exercised.
    bit calm;

    logic signed [DATA_W-1:0] recent_vals [$];

    sorted_list_engine #(.CAPACITY(CAPACITY_DEF)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_list_checker #(.CAPACITY(CAPACITY_DEF)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .errors     (errors),
        .pending    (pending),
        .replies    (replies),
        .full_hits  (full_hits),
        .found_hits (found_hits),
        .miss_hits  (miss_hits),
        .peak_held  (peak_held)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d replies outstanding", cycles, pending);
            $display("FAIL");
            $finish;
        end
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // Values lean toward a small pool and recently inserted ones so that
    // duplicates, hits and successful deletes are common.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return $urandom_range(8) - 4;
        else if (r < 65 && recent_vals.size() > 0)
            return recent_vals[$urandom_range(recent_vals.size() - 1)];
        else if (r < 75)
        begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 0;
                default: return -1;
            endcase
        end
        else
            return $urandom;
    endfunction

    // Reply stalls. Changes happen on the falling edge only.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                stall--;
            end
            else
            begin
                m_tready = 1'b1;
                stall    = pick_gap();
            end
        end
    end

    // Presents one request at a falling edge and holds it until accepted.
    task automatic send_request(input action_t act, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {6'b0, val, act};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (act == ACT_INSERT)
        begin
            recent_vals.push_back(val);
            if (recent_vals.size() > 32)
                void'(recent_vals.pop_front());
        end
        sent++;
        @(negedge clk);
    endtask

    initial
    begin
        int      ins_pct;
        int      del_pct;
        int      r;
        action_t act;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        calm     = 1'b0;
        sent     = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: empty table, extremes, duplicates, ignored code,
        // filling to capacity and an insert into the full table.
        send_request(ACT_SEARCH, 0);
        send_request(ACT_DELETE, 5);
        send_request(ACT_INSERT, 32'sh8000_0000);
        send_request(ACT_INSERT, 32'sh7fff_ffff);
        send_request(ACT_INSERT, 0);
        send_request(ACT_INSERT, 0);
        send_request(ACT_INSERT, -1);
        send_request(ACT_SEARCH, 0);
        send_request(ACT_SEARCH, 5);
        send_request(ACT_NONE, 32'sh5a5a_a5a5);
        send_request(ACT_DELETE, 0);
        for (int i = 0; i < 12; i++)
            send_request(ACT_INSERT, i * 7919 - 40000);
        send_request(ACT_INSERT, 123);
        send_request(ACT_DELETE, 32'sh7fff_ffff);
        send_request(ACT_SEARCH, 32'sh7fff_ffff);

        // Random part in phases of 100 requests. Each phase leans toward
        // filling, draining or a mix, and about one in four runs without gaps.
        ins_pct = 40;
        del_pct = 30;
        for (int n = 0; n < REQUEST_TARGET; )
        begin
            if (n % 100 == 0)
            begin
                calm = ($urandom_range(3) == 0);
                case ($urandom_range(2))
                    0:       begin ins_pct = 75; del_pct = 10; end
                    1:       begin ins_pct = 20; del_pct = 60; end
                    default: begin ins_pct = 40; del_pct = 30; end
                endcase
            end
            r = $urandom_range(99);
            if ($urandom_range(32) == 0)
                act = ACT_NONE;
            else if (r < ins_pct)
                act = ACT_INSERT;
            else if (r < ins_pct + del_pct)
                act = ACT_DELETE;
            else
                act = ACT_SEARCH;
            send_request(act, pick_value());
            if (act != ACT_NONE)
                n++;
        end

        s_tvalid = 1'b0;
        calm     = 1'b1;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d requests, checked %0d replies: %0d full, %0d found, %0d not found.",
                 sent, replies, full_hits, found_hits, miss_hits);
        $display("Peak table fill was %0d of %0d entries.", peak_held, CAPACITY_DEF);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/slc_pkg.sv
rtl/slc_cell.sv
rtl/sorted_list_engine.sv
tb/sv/sorted_list_checker.sv
tb/sv/tb_top.sv
